### rtl/look_at_view_matrix_defines.svh
// Assertion macros shared by the look-at view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define LAVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in reset as well.
`define LAVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Types, constants and index tables shared by the look-at view matrix block.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int INQ_DEPTH     = 2;
    localparam int OUTQ_DEPTH    = 4;

    // One accepted input beat after the front has formed camera minus target.
    typedef struct packed {
        logic [2:0][WORD_W-1:0] cam;
        logic [2:0][WORD_W-1:0] up;
        logic [2:0][WORD_W:0]   dz;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [1:0]        row_index;
        logic [WORD_W-1:0] col0;
        logic [WORD_W-1:0] col1;
        logic [WORD_W-1:0] col2;
        logic [WORD_W-1:0] col3;
        logic              last_row;
        logic              degenerate;
    } t_row;

    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_stat;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQA, N_SQRT, N_DLOAD, N_DIV, N_DONE
    } t_norm_state;

    typedef enum logic [3:0] {
        B_IDLE, B_NZ, B_CX_MUL, B_CX_ACC, B_NX, B_CY_MUL, B_CY_ACC, B_NY,
        B_TR_MUL, B_TR_ACC, B_EMIT
    } t_back_state;

    // Product order of a cross product a x b: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0.
    function automatic logic [1:0] cross_a_idx(input logic [2:0] k);
        case (k)
            3'd0: cross_a_idx = 2'd1;
            3'd1: cross_a_idx = 2'd2;
            3'd2: cross_a_idx = 2'd2;
            3'd3: cross_a_idx = 2'd0;
            3'd4: cross_a_idx = 2'd0;
            3'd5: cross_a_idx = 2'd1;
            default: cross_a_idx = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [2:0] k);
        case (k)
            3'd0: cross_b_idx = 2'd2;
            3'd1: cross_b_idx = 2'd1;
            3'd2: cross_b_idx = 2'd0;
            3'd3: cross_b_idx = 2'd2;
            3'd4: cross_b_idx = 2'd1;
            3'd5: cross_b_idx = 2'd0;
            default: cross_b_idx = 2'd0;
        endcase
    endfunction

endpackage

### rtl/lavm_front.sv
// ----------------------------------------------------------------------------
// lavm_front
// Accepts input beats, forms camera minus target and holds items for the back.
// ----------------------------------------------------------------------------
module lavm_front import lavm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [2:0][WORD_W-1:0]   i_cam,
    input  logic [2:0][WORD_W-1:0]   i_tgt,
    input  logic [2:0][WORD_W-1:0]   i_up,
    output t_item                    o_item,
    output logic                     o_empty,
    input  logic                     i_pop
);

    localparam int AW = $clog2(INQ_DEPTH);
    localparam int CW = $clog2(INQ_DEPTH + 1);

    t_item           r_mem [INQ_DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    t_item           n_item;
    logic            wr_en, rd_en;

    always_comb begin
        n_item.cam = i_cam;
        n_item.up  = i_up;
        for (int i = 0; i < 3; i++) begin
            n_item.dz[i] = {i_cam[i][WORD_W-1], i_cam[i]} - {i_tgt[i][WORD_W-1], i_tgt[i]};
        end
    end

    assign o_full  = (r_count == CW'(INQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wptr <= r_wptr + 1'b1;
            if (rd_en) r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

### rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// Iterative vector normalizer: shift to range, sum of squares, square root,
// then one restoring division per component.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"
module lavm_norm import lavm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2:0][63:0]            i_vec,
    output t_norm_stat                  o_stat,
    output logic [2:0][FRAC_BITS+1:0]   o_axis
);

    localparam int AXW = FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NW  = FRAC_BITS + 32;
    localparam int CW  = $clog2(FRAC_BITS + 1);

    t_norm_state        r_state, n_state;
    logic [63:0]        r_mag [3];
    logic [2:0]         r_sign;
    logic [1:0]         r_idx;
    logic [59:0]        r_prod;
    logic [61:0]        r_acc;
    logic [61:0]        r_s;
    logic [63:0]        r_r;
    logic [62:0]        r_bit;
    logic [30:0]        r_len;
    logic [NW-1:0]      r_num, r_den;
    logic [QW-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic [AXW-1:0]     r_out [3];
    logic               r_ok;

    logic [63:0]        m;
    logic [63:0]        rb, n_r;
    logic               sq_ge, div_ge;
    logic [QW-1:0]      n_q;

    always_comb begin
        m = r_mag[0];
        if (r_mag[1] > m) m = r_mag[1];
        if (r_mag[2] > m) m = r_mag[2];
        rb     = r_r + 64'(r_bit);
        sq_ge  = (64'(r_s) >= rb);
        n_r    = sq_ge ? ((r_r >> 1) + 64'(r_bit)) : (r_r >> 1);
        div_ge = (r_num >= r_den);
        n_q    = {r_q[QW-2:0], div_ge};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE:  if (i_start) n_state = N_SHIFT;
            N_SHIFT: begin
                if (m == '0) begin
                    n_state = N_DONE;
                end else if (m[63:30] == '0 && m[29]) begin
                    n_state = N_SQ;
                end
            end
            N_SQ:    n_state = N_SQA;
            N_SQA:   n_state = (r_idx == 2'd2) ? N_SQRT : N_SQ;
            N_SQRT:  if (r_bit[0]) n_state = N_DLOAD;
            N_DLOAD: n_state = N_DIV;
            N_DIV: begin
                if (r_cnt == '0) n_state = (r_idx == 2'd2) ? N_DONE : N_DLOAD;
            end
            N_DONE:  n_state = N_IDLE;
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= N_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_sign[i] <= i_vec[i][63];
                        r_mag[i]  <= i_vec[i][63] ? (64'd0 - i_vec[i]) : i_vec[i];
                    end
                    r_ok <= 1'b1;
                end
            end
            N_SHIFT: begin
                if (m == '0) begin
                    r_ok <= 1'b0;
                    for (int i = 0; i < 3; i++) r_out[i] <= '0;
                end else if (m[63:30] != '0) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (!m[29]) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end else begin
                    r_idx <= 2'd0;
                    r_acc <= '0;
                end
            end
            N_SQ: r_prod <= r_mag[r_idx][29:0] * r_mag[r_idx][29:0];
            N_SQA: begin
                r_acc <= r_acc + 62'(r_prod);
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd2) begin
                    r_s   <= r_acc + 62'(r_prod);
                    r_r   <= '0;
                    r_bit <= 63'd1 << 62;
                end
            end
            N_SQRT: begin
                if (sq_ge) r_s <= r_s - rb[61:0];
                r_r   <= n_r;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_len <= n_r[30:0];
                    r_idx <= 2'd0;
                end
            end
            N_DLOAD: begin
                r_num <= (NW'(r_mag[r_idx][29:0]) << FRAC_BITS) + NW'(r_len >> 1);
                r_den <= NW'(r_len) << FRAC_BITS;
                r_q   <= '0;
                r_cnt <= CW'(FRAC_BITS);
            end
            N_DIV: begin
                if (div_ge) r_num <= r_num - r_den;
                r_den <= r_den >> 1;
                r_q   <= n_q;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_out[r_idx] <= r_sign[r_idx] ? (AXW'(0) - AXW'(n_q)) : AXW'(n_q);
                    r_idx        <= r_idx + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.done = (r_state == N_DONE);
    assign o_stat.ok   = r_ok;
    always_comb begin
        for (int i = 0; i < 3; i++) o_axis[i] = r_out[i];
    end

    // A unit vector component never exceeds one in magnitude; checked both ways for x, upper bound only for y and z.
    `LAVM_ASSERT(a_norm_range, i_clk, i_rst_n,
        o_stat.done |-> ($signed(r_out[0]) <= $signed(AXW'(1) << FRAC_BITS)
            && $signed(r_out[0]) >= -$signed(AXW'(1) << FRAC_BITS)
            && $signed(r_out[1]) <= $signed(AXW'(1) << FRAC_BITS)
            && $signed(r_out[2]) <= $signed(AXW'(1) << FRAC_BITS)),
        "normalized component out of range")
    `LAVM_ASSERT(a_norm_start_idle, i_clk, i_rst_n,
        i_start |-> (r_state == N_IDLE), "normalizer started while busy")

endmodule

### rtl/lavm_back.sv
// ----------------------------------------------------------------------------
// lavm_back
// Sequencer that builds the three axes and translations for one item and
// writes its four rows into the result queue.
// ----------------------------------------------------------------------------
module lavm_back import lavm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_in_empty,
    output logic    o_in_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_row    o_out_row
);

    localparam int AXW = FRAC_BITS + 2;

    t_back_state                r_state, n_state;
    logic [2:0][WORD_W-1:0]     r_cam, r_up;
    logic [2:0][AXW-1:0]        r_x, r_y, r_z;
    logic signed [63:0]         r_cross [3];
    logic signed [63:0]         r_prod, r_acc;
    logic signed [WORD_W-1:0]   r_trans [3];
    logic [2:0]                 r_k;
    logic [1:0]                 r_row, r_col;
    logic                       r_ok;

    logic                       norm_start;
    logic [2:0][63:0]           norm_vec;
    t_norm_stat                 norm_stat;
    logic [2:0][AXW-1:0]        norm_axis;
    logic signed [32:0]         op_a, op_b;
    logic signed [65:0]         prod;
    logic signed [63:0]         dot, rnd, neg;
    logic [1:0]                 ai, bi;
    logic [2:0][AXW-1:0]        tr_axis;

    lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_vec),
        .o_stat  (norm_stat),
        .o_axis  (norm_axis)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            norm_vec[i] = (r_state == B_IDLE) ? 64'($signed(i_item.dz[i])) : r_cross[i];
        end
        // The last cross product term is still being formed in the cycle
        // that starts the normalizer, so it is taken straight from the adder.
        if (r_state != B_IDLE) norm_vec[2] = r_acc - r_prod;
    end

    // Shared multiplier operand selection.
    always_comb begin
        ai = cross_a_idx(r_k);
        bi = cross_b_idx(r_k);
        case (r_row)
            2'd0:    tr_axis = r_x;
            2'd1:    tr_axis = r_y;
            default: tr_axis = r_z;
        endcase
        case (r_state)
            B_CX_MUL: begin
                op_a = 33'($signed(r_up[ai]));
                op_b = 33'($signed(r_z[bi]));
            end
            B_CY_MUL: begin
                op_a = 33'($signed(r_z[ai]));
                op_b = 33'($signed(r_x[bi]));
            end
            default: begin
                op_a = 33'($signed(tr_axis[r_col]));
                op_b = 33'($signed(r_cam[r_col]));
            end
        endcase
        prod = op_a * op_b;
    end

    // Translation is minus the rounded dot product, saturated to a word.
    always_comb begin
        dot = ((r_col == 2'd0) ? 64'sd0 : r_acc) + r_prod;
        rnd = (dot + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        neg = 64'sd0 - rnd;
    end

    always_comb begin
        n_state    = r_state;
        o_in_pop   = 1'b0;
        norm_start = 1'b0;
        o_out_push = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_in_empty) begin
                    o_in_pop   = 1'b1;
                    norm_start = 1'b1;
                    n_state    = B_NZ;
                end
            end
            B_NZ:     if (norm_stat.done) n_state = B_CX_MUL;
            B_CX_MUL: n_state = B_CX_ACC;
            B_CX_ACC: begin
                if (r_k == 3'd5) begin
                    norm_start = 1'b1;
                    n_state    = B_NX;
                end else begin
                    n_state = B_CX_MUL;
                end
            end
            B_NX:     if (norm_stat.done) n_state = B_CY_MUL;
            B_CY_MUL: n_state = B_CY_ACC;
            B_CY_ACC: begin
                if (r_k == 3'd5) begin
                    norm_start = 1'b1;
                    n_state    = B_NY;
                end else begin
                    n_state = B_CY_MUL;
                end
            end
            B_NY:     if (norm_stat.done) n_state = B_TR_MUL;
            B_TR_MUL: n_state = B_TR_ACC;
            B_TR_ACC: begin
                if (r_col == 2'd2 && r_row == 2'd2) n_state = B_EMIT;
                else                                n_state = B_TR_MUL;
            end
            B_EMIT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_row == 2'd3) n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cam <= i_item.cam;
                r_up  <= i_item.up;
            end
            B_NZ: begin
                if (norm_stat.done) begin
                    r_z  <= norm_axis;
                    r_ok <= norm_stat.ok;
                    r_k  <= 3'd0;
                end
            end
            B_NX: begin
                if (norm_stat.done) begin
                    r_x  <= norm_axis;
                    r_ok <= r_ok & norm_stat.ok;
                    r_k  <= 3'd0;
                end
            end
            B_NY: begin
                if (norm_stat.done) begin
                    r_y   <= norm_axis;
                    r_ok  <= r_ok & norm_stat.ok;
                    r_row <= 2'd0;
                    r_col <= 2'd0;
                end
            end
            B_CX_MUL, B_CY_MUL, B_TR_MUL: r_prod <= prod[63:0];
            B_CX_ACC, B_CY_ACC: begin
                if (!r_k[0]) r_acc <= r_prod;
                else         r_cross[r_k[2:1]] <= r_acc - r_prod;
                r_k <= r_k + 3'd1;
            end
            B_TR_ACC: begin
                r_acc <= dot;
                if (r_col == 2'd2) begin
                    if (neg > 64'sd2147483647) begin
                        r_trans[r_row] <= 32'sh7fffffff;
                    end else if (neg < -64'sd2147483648) begin
                        r_trans[r_row] <= 32'sh80000000;
                    end else begin
                        r_trans[r_row] <= neg[WORD_W-1:0];
                    end
                    r_col <= 2'd0;
                    r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
            B_EMIT: if (!i_out_full) r_row <= r_row + 2'd1;
            default: ;
        endcase
    end

    always_comb begin
        o_out_row.row_index  = r_row;
        o_out_row.last_row   = (r_row == 2'd3);
        o_out_row.degenerate = !r_ok;
        o_out_row.col0 = '0;
        o_out_row.col1 = '0;
        o_out_row.col2 = '0;
        o_out_row.col3 = WORD_W'(1) << FRAC_BITS;
        case (r_row)
            2'd0: begin
                o_out_row.col0 = WORD_W'($signed(r_x[0]));
                o_out_row.col1 = WORD_W'($signed(r_x[1]));
                o_out_row.col2 = WORD_W'($signed(r_x[2]));
                o_out_row.col3 = r_trans[0];
            end
            2'd1: begin
                o_out_row.col0 = WORD_W'($signed(r_y[0]));
                o_out_row.col1 = WORD_W'($signed(r_y[1]));
                o_out_row.col2 = WORD_W'($signed(r_y[2]));
                o_out_row.col3 = r_trans[1];
            end
            2'd2: begin
                o_out_row.col0 = WORD_W'($signed(r_z[0]));
                o_out_row.col1 = WORD_W'($signed(r_z[1]));
                o_out_row.col2 = WORD_W'($signed(r_z[2]));
                o_out_row.col3 = r_trans[2];
            end
            default: ;
        endcase
    end

endmodule

### rtl/lavm_outq.sv
// ----------------------------------------------------------------------------
// lavm_outq
// Result queue that holds finished rows until the consumer takes them.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"
module lavm_outq import lavm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_row    i_row,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_row    o_row
);

    localparam int AW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    t_row           r_mem [OUTQ_DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           wr_en, rd_en;

    assign o_full  = (r_count == CW'(OUTQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_row   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wptr <= r_wptr + 1'b1;
            if (rd_en) r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + CW'(wr_en) - CW'(rd_en);
        end
    end

    `LAVM_ASSERT(a_outq_no_overrun, i_clk, i_rst_n,
        !(i_push && o_full), "row written into a full result queue")
    `LAVM_ASSERT(a_outq_last_row, i_clk, i_rst_n,
        (wr_en && i_row.last_row) |-> (i_row.row_index == 2'd3),
        "last row flag on a row other than row three")

endmodule

### rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point, four rows per item.
// ----------------------------------------------------------------------------
// Each input beat (camera, target, up) yields four result beats, rows 0 to 3.
// An item occupies the sequencer longer for each range-shift step in its
// three normalizations and while the result side stalls; a zero-length
// vector skips its normalization work and finishes sooner. Most of that
// time goes to the single shared normalizer, which per axis runs a
// one-bit-per-cycle range shift, a 32-step square root and a restoring
// divide of FRAC_BITS + 1 steps per component. A two-entry input queue lets
// the next items be accepted while one is in work, and a four-row result
// queue lets the sequencer finish while the consumer stalls.
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [WORD_W-1:0]   i_camera_x,
    input  logic [WORD_W-1:0]   i_camera_y,
    input  logic [WORD_W-1:0]   i_camera_z,
    input  logic [WORD_W-1:0]   i_target_x,
    input  logic [WORD_W-1:0]   i_target_y,
    input  logic [WORD_W-1:0]   i_target_z,
    input  logic [WORD_W-1:0]   i_up_x,
    input  logic [WORD_W-1:0]   i_up_y,
    input  logic [WORD_W-1:0]   i_up_z,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_row_index,
    output logic [WORD_W-1:0]   o_col0,
    output logic [WORD_W-1:0]   o_col1,
    output logic [WORD_W-1:0]   o_col2,
    output logic [WORD_W-1:0]   o_col3,
    output logic                o_last_row,
    output logic                o_degenerate
);

    t_item  item;
    logic   in_empty, in_pop;
    logic   out_full, out_push;
    t_row   back_row, head_row;

    lavm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_cam   ({i_camera_z, i_camera_y, i_camera_x}),
        .i_tgt   ({i_target_z, i_target_y, i_target_x}),
        .i_up    ({i_up_z, i_up_y, i_up_x}),
        .o_item  (item),
        .o_empty (in_empty),
        .i_pop   (in_pop)
    );

    lavm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_in_empty (in_empty),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_row  (back_row)
    );

    lavm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_row   (back_row),
        .o_full  (out_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_row   (head_row)
    );

    assign o_row_index  = head_row.row_index;
    assign o_col0       = head_row.col0;
    assign o_col1       = head_row.col1;
    assign o_col2       = head_row.col2;
    assign o_col3       = head_row.col3;
    assign o_last_row   = head_row.last_row;
    assign o_degenerate = head_row.degenerate;

endmodule
